// File: hdl/dstf_pkg.sv
// Package with shared types and constants for the decimal string converter.
`default_nettype none
package dstf_pkg;
  localparam logic [7:0] CHAR_DOT  = 8'd46;
  localparam logic [7:0] CHAR_ZERO = 8'd48;
  localparam logic [30:0] INT_MAX  = 31'h7FFFFFFF;

  // One finished string, handed from the front end to the divider.
  typedef struct packed {
    logic [30:0] integer_part;
    logic [29:0] numerator;
    logic [3:0]  frac_len;
    logic        not_a_number;
    logic        overflow;
    logic        tail_valid;
    logic [7:0]  tail_index;
  } job_t;

  typedef struct packed {
    logic [30:0] integer_part;
    logic [31:0] fraction_bits;
    logic        not_a_number;
    logic        overflow;
    logic        tail_valid;
    logic [7:0]  tail_index;
  } result_t;

  function automatic logic [33:0] pow_ten(input logic [3:0] n);
    logic [33:0] p;
    p = 34'd1;
    for (int i = 0; i < 9; i++) begin
      if (i < int'(n)) p = p * 34'd10;
    end
    return p;
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return (c == 8'd32) || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'd48) && (c <= 8'd57);
  endfunction
endpackage
`default_nettype wire

// File: hdl/dstf_front.sv
// Character scanner: accumulates one string and emits a conversion job.
`default_nettype none
module dstf_front #(
  parameter int MAX_FRACTION_DIGITS = 9,
  parameter int MAX_STRING_LENGTH = 256
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       mode,
  input  wire logic       in_take,
  input  wire logic [7:0] char_code,
  input  wire logic       last,
  output dstf_pkg::job_t  job,
  output logic            job_push
);
  localparam int PW = $clog2(MAX_STRING_LENGTH + 1);

  typedef enum logic [5:0] {
    PH_LEAD = 6'b000001, PH_INT = 6'b000010, PH_SEEK = 6'b000100,
    PH_FRAC = 6'b001000, PH_TAILSP = 6'b010000, PH_DONE = 6'b100000
  } phase_t;

  phase_t phase, phase_next, ph;
  logic [30:0] acc, acc_next;
  logic [29:0] num, num_next;
  logic [3:0] flen, flen_next;
  logic [PW-1:0] pos, pos_next;
  logic [PW-1:0] tpos, tpos_next;
  logic tseen, tseen_next, ovf, ovf_next, nsp, nsp_next;
  logic started, strict, strict_next, drun, drun_next;
  logic [34:0] prod;
  logic [3:0] d;
  logic sp, dg;

  always_comb begin
    phase_next = phase; acc_next = acc; num_next = num; flen_next = flen;
    pos_next = pos; tpos_next = tpos; tseen_next = tseen; ovf_next = ovf;
    nsp_next = nsp; strict_next = strict; drun_next = drun;
    sp = dstf_pkg::is_space(char_code);
    dg = dstf_pkg::is_digit(char_code);
    d = 4'(char_code - dstf_pkg::CHAR_ZERO);
    prod = {4'd0, acc} * 35'd10 + {31'd0, d};
    ph = phase;
    if (!started) begin
      strict_next = mode;
      ph = mode ? PH_LEAD : PH_INT;
    end
    phase_next = ph;
    if (ph != PH_DONE) begin
      if (char_code == 8'd0 || 32'(pos) >= MAX_STRING_LENGTH) begin
        if (ph == PH_TAILSP) begin
          tpos_next = pos; tseen_next = 1'b1;
        end
        phase_next = PH_DONE;
      end else begin
        pos_next = pos + 1'b1;
        if (ph == PH_LEAD && !sp) begin
          nsp_next = 1'b1; ph = PH_INT;
        end
        if (ph == PH_INT) begin
          if (dg) begin
            if (prod > 35'(dstf_pkg::INT_MAX)) begin
              acc_next = dstf_pkg::INT_MAX; ovf_next = 1'b1;
            end else acc_next = prod[30:0];
          end else ph = PH_SEEK;
        end
        unique case (ph)
          PH_SEEK: begin
            if (char_code == dstf_pkg::CHAR_DOT) begin
              ph = PH_FRAC; drun_next = 1'b1;
            end
          end
          PH_FRAC: begin
            if (strict_next && sp) ph = PH_TAILSP;
            else begin
              if (32'(flen) <= MAX_FRACTION_DIGITS) flen_next = flen + 1'b1;
              if (32'(flen_next) > MAX_FRACTION_DIGITS) begin
                ovf_next = 1'b1; drun_next = 1'b0;
              end else if (drun && dg) num_next = 30'(num * 30'd10 + 30'(d));
              else drun_next = 1'b0;
            end
          end
          PH_TAILSP: begin
            if (!sp) begin
              tpos_next = pos; tseen_next = 1'b1; ph = PH_DONE;
            end
          end
          default: ;
        endcase
        phase_next = ph;
      end
    end
    if (last && phase_next == PH_TAILSP) begin
      tpos_next = pos_next; tseen_next = 1'b1;
    end
  end

  always_comb begin
    job.integer_part = acc_next;
    job.numerator    = num_next;
    job.frac_len     = flen_next;
    job.not_a_number = strict_next && !nsp_next;
    job.overflow     = ovf_next;
    job.tail_valid   = tseen_next;
    job.tail_index   = !tseen_next ? 8'd0 :
                       (32'(tpos_next) > 255) ? 8'd255 : 8'(tpos_next);
    job_push = in_take && last;
  end

  always_ff @(posedge clk) begin
    if (rst || (in_take && last)) begin
      phase <= PH_LEAD; acc <= '0; num <= '0; flen <= '0; pos <= '0;
      tpos <= '0; tseen <= 1'b0; ovf <= 1'b0; nsp <= 1'b0;
      started <= 1'b0; strict <= 1'b0; drun <= 1'b0;
    end else if (in_take) begin
      phase <= phase_next; acc <= acc_next; num <= num_next;
      flen <= flen_next; pos <= pos_next; tpos <= tpos_next;
      tseen <= tseen_next; ovf <= ovf_next; nsp <= nsp_next;
      started <= 1'b1; strict <= strict_next; drun <= drun_next;
    end
  end
endmodule
`default_nettype wire

// File: hdl/dstf_queue.sv
// Two-entry job queue between the scanner and the divider.
`default_nettype none
module dstf_queue (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire dstf_pkg::job_t wr_data,
  input  wire logic      wr_en,
  output logic           full,
  output dstf_pkg::job_t rd_data,
  output logic           rd_valid,
  input  wire logic      rd_en
);
  dstf_pkg::job_t mem [2];
  logic wp, rp;
  logic [1:0] count;

  assign full = count == 2'd2;
  assign rd_valid = count != 2'd0;
  assign rd_data = mem[rp];

  always_ff @(posedge clk) begin
    if (wr_en) mem[wp] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= 1'b0; rp <= 1'b0; count <= 2'd0;
    end else begin
      if (wr_en) wp <= ~wp;
      if (rd_en) rp <= ~rp;
      count <= count + {1'b0, wr_en} - {1'b0, rd_en};
    end
  end
endmodule
`default_nettype wire

// File: hdl/dstf_divider.sv
// Restoring divider: numerator * 2^32 over a power of ten, one bit a cycle.
`default_nettype none
module dstf_divider #(
  parameter int MAX_FRACTION_DIGITS = 9
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire dstf_pkg::job_t job,
  input  wire logic        job_valid,
  output logic             job_pop,
  output dstf_pkg::result_t res,
  output logic             res_valid,
  input  wire logic        res_ready
);
  typedef enum logic [1:0] {S_IDLE = 2'b01, S_RUN = 2'b10} state_t;
  state_t state;
  logic [5:0] cnt;
  logic [33:0] divisor, rem;
  logic [31:0] quo;
  logic [29:0] numer;
  logic [34:0] trial;
  logic zero_frac;
  dstf_pkg::job_t hold;

  assign job_pop = state == S_IDLE && job_valid && !res_valid;
  // Shift in numerator bits first, then 32 zero bits; only the last 32 quotient bits matter.
  assign trial = {rem, (cnt < 6'd30) ? numer[29 - cnt[4:0]] : 1'b0};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE; res_valid <= 1'b0; cnt <= '0;
    end else begin
      if (res_valid && res_ready) res_valid <= 1'b0;
      unique case (state)
        S_IDLE: if (job_pop) begin
          state <= S_RUN; cnt <= '0;
        end
        S_RUN: begin
          if (cnt == 6'd61) begin
            state <= S_IDLE; res_valid <= 1'b1;
          end
          cnt <= cnt + 1'b1;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (job_pop) begin
      hold <= job; numer <= job.numerator; rem <= '0; quo <= '0;
      divisor <= dstf_pkg::pow_ten(job.frac_len);
      zero_frac <= 32'(job.frac_len) > MAX_FRACTION_DIGITS;
    end else if (state == S_RUN) begin
      if (trial >= {1'b0, divisor}) begin
        rem <= 34'(trial - {1'b0, divisor}); quo <= {quo[30:0], 1'b1};
      end else begin
        rem <= trial[33:0]; quo <= {quo[30:0], 1'b0};
      end
    end
  end

  always_comb begin
    res.integer_part  = hold.integer_part;
    res.fraction_bits = zero_frac ? 32'd0 : quo;
    res.not_a_number  = hold.not_a_number;
    res.overflow      = hold.overflow;
    res.tail_valid    = hold.tail_valid;
    res.tail_index    = hold.tail_index;
  end
endmodule
`default_nettype wire

// File: hdl/decimal_string_to_fixed.sv
// Top level of the streaming decimal string to fixed-point converter.
`default_nettype none
// Takes one character per cycle; on the character marked last a job holding the
// integer part, fraction numerator and flags goes into a two-entry queue. A shared
// bit-serial divider then forms the 0.32 fraction of each string: it loads the
// job, runs 62 shift steps and hands off the result when out_ready is high, and
// takes no new job until that result is taken. A stalled output holds the
// divider, and once the queue is full the input stalls. parse_mode (reset 1,
// strict) is sampled at the first character of each string.
module decimal_string_to_fixed #(
  parameter int MAX_FRACTION_DIGITS = 9,
  parameter int MAX_STRING_LENGTH = 256
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  char_code,
  input  wire logic        last,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [30:0]      integer_part,
  output logic [31:0]      fraction_bits,
  output logic             not_a_number,
  output logic             overflow,
  output logic             tail_valid,
  output logic [7:0]       tail_index,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_data
);
  logic parse_mode, in_take, push, qfull, qvalid, pop;
  dstf_pkg::job_t job, qjob;
  dstf_pkg::result_t res;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) parse_mode <= 1'b1;
    else if (cfg_valid) parse_mode <= cfg_data;
  end

  assign in_ready = !qfull;
  assign in_take = in_valid && in_ready;

  dstf_front #(.MAX_FRACTION_DIGITS(MAX_FRACTION_DIGITS),
               .MAX_STRING_LENGTH(MAX_STRING_LENGTH)) u_front (
    .clk, .rst, .mode(parse_mode), .in_take, .char_code, .last,
    .job, .job_push(push));

  dstf_queue u_queue (.clk, .rst, .wr_data(job), .wr_en(push), .full(qfull),
    .rd_data(qjob), .rd_valid(qvalid), .rd_en(pop));

  dstf_divider #(.MAX_FRACTION_DIGITS(MAX_FRACTION_DIGITS)) u_div (
    .clk, .rst, .job(qjob), .job_valid(qvalid), .job_pop(pop),
    .res, .res_valid(out_valid), .res_ready(out_ready));

  assign integer_part  = res.integer_part;
  assign fraction_bits = res.fraction_bits;
  assign not_a_number  = res.not_a_number;
  assign overflow      = res.overflow;
  assign tail_valid    = res.tail_valid;
  assign tail_index    = res.tail_index;

  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    qfull |-> !push) else $error("job pushed into full queue");
  a_nan_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && not_a_number |-> integer_part == 31'd0)
    else $error("not-a-number with nonzero integer");
  a_pop_idle: assert property (@(posedge clk) disable iff (rst)
    pop |-> qvalid && !out_valid) else $error("pop while busy");
endmodule
`default_nettype wire
